FILE: design/median_filter_3x3_unit_defines.svh
`ifndef MEDIAN_FILTER_3X3_UNIT_DEFINES_SVH
`define MEDIAN_FILTER_3X3_UNIT_DEFINES_SVH

// Same-cycle implication on i_clk, off while reset is low.
`define MF3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, off while reset is low.
`define MF3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mf3_pkg.sv
`default_nettype none

package mf3_pkg;

    localparam int ROW_W      = 16;
    localparam int COL_OUT_W  = 10;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
    localparam logic [FH_W-1:0] FH_RESET = 16'd1024;

    localparam int NUM_RES  = 4;   // results one pixel can release
    localparam int WIN_COLS = 3;
    localparam int WIN_ROWS = 3;
    localparam int QDEPTH   = 4;

    // Which results a pixel releases, plus the column cases that steer
    // the left column of the window.
    typedef struct packed {
        logic [NUM_RES-1:0] emit;
        logic               col_zero;
        logic               col_one;
    } t_emit;

    localparam int EMIT_W = $bits(t_emit);

endpackage

`default_nettype wire

FILE: design/mf3_front.sv
`default_nettype none

module mf3_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [PIXEL_BITS-1:0]                  i_pixel_in,
    output logic                                        o_push,
    input  wire logic                                   i_full,
    output logic [mf3_pkg::WIN_COLS*mf3_pkg::WIN_ROWS*PIXEL_BITS-1:0] o_win,
    output logic [mf3_pkg::ROW_W-1:0]                   o_row,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] o_col,
    output mf3_pkg::t_emit                              o_emit
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int P  = PIXEL_BITS;

    logic [mf3_pkg::FW_W-1:0] r_frame_width;
    logic [mf3_pkg::FH_W-1:0] r_frame_height;
    logic [CW-1:0]            w_last;
    logic [mf3_pkg::ROW_W-1:0] h_last;

    logic [CW-1:0]             r_col;
    logic [mf3_pkg::ROW_W-1:0] r_row;
    logic                      accept;
    logic                      lastc;
    logic                      lastr;
    mf3_pkg::t_emit            n_emit;

    logic                      r_s1_v;
    logic [P-1:0]              r_s1_pix;
    logic [CW-1:0]             r_s1_col;
    logic [mf3_pkg::ROW_W-1:0] r_s1_row;
    mf3_pkg::t_emit            r_s1_emit;
    logic                      r_byp;
    logic [P-1:0]              r_byp_u;
    logic [P-1:0]              r_byp_l;
    logic [P-1:0]              r_rd_u;
    logic [P-1:0]              r_rd_l;
    logic [P-1:0]              s1_u;
    logic [P-1:0]              s1_l;
    logic                      leave;

    logic [P-1:0] r_mem_u [MAX_WIDTH];
    logic [P-1:0] r_mem_l [MAX_WIDTH];

    logic [mf3_pkg::WIN_ROWS-1:0][P-1:0] r_win [mf3_pkg::WIN_COLS];
    logic [mf3_pkg::WIN_ROWS-1:0][P-1:0] n_win [mf3_pkg::WIN_COLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mf3_pkg::FW_RESET;
            r_frame_height <= mf3_pkg::FH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mf3_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[mf3_pkg::FW_W-1:0];
                end
                mf3_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[mf3_pkg::FH_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // zero width counts as one, anything above the line store saturates
    always_comb begin
        if (r_frame_width == '0) begin
            w_last = '0;
        end else if (r_frame_width > MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(r_frame_width - 1'b1);
        end
        h_last = (r_frame_height == '0) ? '0 : r_frame_height - 1'b1;
    end

    assign leave      = r_s1_v && ((r_s1_emit.emit == '0) || !i_full);
    assign o_in_ready = !r_s1_v || leave;
    assign accept     = i_in_valid && o_in_ready;

    assign lastc = (r_col >= w_last);
    assign lastr = (r_row >= h_last);

    always_comb begin
        n_emit.emit[0]  = (r_row != '0) && (r_col != '0);
        n_emit.emit[1]  = (r_row != '0) && lastc;
        n_emit.emit[2]  = lastr && (r_col != '0);
        n_emit.emit[3]  = lastr && lastc;
        n_emit.col_zero = (r_col == '0);
        n_emit.col_one  = (r_col == CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (lastc) begin
                r_col <= '0;
                r_row <= lastr ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= 1'b1;
        end else if (leave) begin
            r_s1_v <= 1'b0;
        end
    end

    // A one-pixel-wide frame reads the entry that the leaving pixel writes
    // in the same cycle: forward its write data.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= i_pixel_in;
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_emit <= n_emit;
            r_byp     <= leave && (r_s1_col == r_col);
            r_byp_u   <= s1_l;
            r_byp_l   <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_u <= r_mem_u[r_col];
        end
        if (leave) begin
            r_mem_u[r_s1_col] <= s1_l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_l <= r_mem_l[r_col];
        end
        if (leave) begin
            r_mem_l[r_s1_col] <= r_s1_pix;
        end
    end

    assign s1_u = r_byp ? r_byp_u : r_rd_u;
    assign s1_l = r_byp ? r_byp_l : r_rd_l;

    always_comb begin
        n_win[0]    = r_win[1];
        n_win[1]    = r_win[2];
        n_win[2][0] = s1_u;
        n_win[2][1] = s1_l;
        n_win[2][2] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < mf3_pkg::WIN_COLS; s++) begin
                r_win[s] <= '0;
            end
        end else if (leave) begin
            for (int s = 0; s < mf3_pkg::WIN_COLS; s++) begin
                r_win[s] <= n_win[s];
            end
        end
    end

    always_comb begin
        for (int s = 0; s < mf3_pkg::WIN_COLS; s++) begin
            for (int k = 0; k < mf3_pkg::WIN_ROWS; k++) begin
                o_win[(s*mf3_pkg::WIN_ROWS+k)*P +: P] = n_win[s][k];
            end
        end
    end

    assign o_push = leave && (r_s1_emit.emit != '0);
    assign o_row  = r_s1_row;
    assign o_col  = r_s1_col;
    assign o_emit = r_s1_emit;

endmodule

`default_nettype wire

FILE: design/mf3_fifo.sv
`default_nettype none

module mf3_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [NW-1:0] r_cnt;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/mf3_back.sv
`default_nettype none

module mf3_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    input  wire logic [mf3_pkg::WIN_COLS*mf3_pkg::WIN_ROWS*PIXEL_BITS-1:0] i_win,
    input  wire logic [mf3_pkg::ROW_W-1:0]              i_row,
    input  wire logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] i_col,
    input  wire mf3_pkg::t_emit                         i_emit,
    output logic                                        o_pop,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [PIXEL_BITS-1:0]                       o_pixel_out,
    output logic [mf3_pkg::ROW_W-1:0]                   o_out_row,
    output logic [mf3_pkg::COL_OUT_W-1:0]               o_out_col,
    output logic                                        o_frame_done
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CXW = (CW > mf3_pkg::COL_OUT_W) ? CW : mf3_pkg::COL_OUT_W;
    localparam int P   = PIXEL_BITS;
    localparam int NR  = mf3_pkg::NUM_RES;

    function automatic logic [P-1:0] min2(input logic [P-1:0] a, input logic [P-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [P-1:0] max2(input logic [P-1:0] a, input logic [P-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [P-1:0] med3(input logic [P-1:0] a, input logic [P-1:0] b,
                                          input logic [P-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // returns {hi, mid, lo}
    function automatic logic [2:0][P-1:0] sort3(input logic [2:0][P-1:0] x);
        logic [P-1:0] l1;
        logic [P-1:0] h1;
        logic [P-1:0] m0;
        logic [2:0][P-1:0] y;
        l1   = min2(x[0], x[1]);
        h1   = max2(x[0], x[1]);
        m0   = min2(h1, x[2]);
        y[2] = max2(h1, x[2]);
        y[1] = max2(l1, m0);
        y[0] = min2(l1, m0);
        return y;
    endfunction

    logic [NR-1:0] r_served;
    logic [NR-1:0] pending;
    logic [NR-1:0] sel;
    logic          last;
    logic          k_odd;
    logic          lastmode;
    logic          en;
    logic          issue;

    logic [mf3_pkg::WIN_ROWS-1:0][P-1:0] win [mf3_pkg::WIN_COLS];
    logic [1:0]                slot [3];
    logic [2:0][P-1:0]         sel_col [3];
    logic [mf3_pkg::ROW_W-1:0] orow;
    logic [CW-1:0]             ocol;

    logic                      r_a_v;
    logic [2:0][P-1:0]         r_a_cols [3];
    logic [P-1:0]              r_a_ctr;
    logic [mf3_pkg::ROW_W-1:0] r_a_row;
    logic [CW-1:0]             r_a_col;
    logic                      r_a_done;

    logic                      r_b_v;
    logic [2:0][P-1:0]         r_b_cols [3];
    logic [P-1:0]              r_b_ctr;
    logic [mf3_pkg::ROW_W-1:0] r_b_row;
    logic [CW-1:0]             r_b_col;
    logic                      r_b_done;

    logic                      r_c_v;
    logic [P-1:0]              r_c_mx;
    logic [P-1:0]              r_c_md;
    logic [P-1:0]              r_c_mn;
    logic [P-1:0]              r_c_ctr;
    logic [mf3_pkg::ROW_W-1:0] r_c_row;
    logic [CW-1:0]             r_c_col;
    logic                      r_c_done;

    logic                      r_d_v;
    logic [P-1:0]              r_d_pix;
    logic [mf3_pkg::ROW_W-1:0] r_d_row;
    logic [CW-1:0]             r_d_col;
    logic                      r_d_done;
    logic [P-1:0]              med;
    logic [CXW-1:0]            col_ext;

    // one result per cycle from the head entry while the output is not stalled, lowest pending first
    assign pending  = i_emit.emit & ~r_served;
    assign sel      = pending & (~pending + 1'b1);
    assign last     = ((pending & ~sel) == '0);
    assign k_odd    = sel[1] | sel[3];
    assign lastmode = sel[2] | sel[3];

    assign en    = !r_d_v || i_out_ready;
    assign issue = en && i_valid;
    assign o_pop = issue && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_served <= '0;
        end else if (issue) begin
            r_served <= last ? '0 : (r_served | sel);
        end
    end

    always_comb begin
        for (int s = 0; s < mf3_pkg::WIN_COLS; s++) begin
            for (int k = 0; k < mf3_pkg::WIN_ROWS; k++) begin
                win[s][k] = i_win[(s*mf3_pkg::WIN_ROWS+k)*P +: P];
            end
        end
    end

    // Left column replicates the centre one at column 0; bottom result row
    // replicates the newest row; top row 0 replicates itself upward.
    always_comb begin
        orow    = lastmode ? i_row : i_row - 1'b1;
        ocol    = k_odd ? i_col : i_col - 1'b1;
        slot[0] = k_odd ? (i_emit.col_zero ? 2'd2 : 2'd1) : (i_emit.col_one ? 2'd1 : 2'd0);
        slot[1] = k_odd ? 2'd2 : 2'd1;
        slot[2] = 2'd2;
        for (int j = 0; j < 3; j++) begin
            if (lastmode) begin
                sel_col[j][0] = (orow == '0) ? win[slot[j]][2] : win[slot[j]][1];
                sel_col[j][1] = win[slot[j]][2];
            end else begin
                sel_col[j][0] = (orow == '0) ? win[slot[j]][1] : win[slot[j]][0];
                sel_col[j][1] = win[slot[j]][1];
            end
            sel_col[j][2] = win[slot[j]][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    assign med = med3(r_c_mx, r_c_md, r_c_mn);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_a_cols[j] <= sel_col[j];
                r_b_cols[j] <= sort3(r_a_cols[j]);
            end
            r_a_ctr  <= sel_col[1][1];
            r_a_row  <= orow;
            r_a_col  <= ocol;
            r_a_done <= sel[3];

            r_b_ctr  <= r_a_ctr;
            r_b_row  <= r_a_row;
            r_b_col  <= r_a_col;
            r_b_done <= r_a_done;

            r_c_mx   <= max2(max2(r_b_cols[0][0], r_b_cols[1][0]), r_b_cols[2][0]);
            r_c_md   <= med3(r_b_cols[0][1], r_b_cols[1][1], r_b_cols[2][1]);
            r_c_mn   <= min2(min2(r_b_cols[0][2], r_b_cols[1][2]), r_b_cols[2][2]);
            r_c_ctr  <= r_b_ctr;
            r_c_row  <= r_b_row;
            r_c_col  <= r_b_col;
            r_c_done <= r_b_done;

            r_d_pix  <= (med == '0) ? r_c_ctr : med;
            r_d_row  <= r_c_row;
            r_d_col  <= r_c_col;
            r_d_done <= r_c_done;
        end
    end

    assign col_ext      = CXW'(r_d_col);
    assign o_out_valid  = r_d_v;
    assign o_pixel_out  = r_d_pix;
    assign o_out_row    = r_d_row;
    assign o_out_col    = col_ext[mf3_pkg::COL_OUT_W-1:0];
    assign o_frame_done = r_d_done;

endmodule

`default_nettype wire

FILE: design/median_filter_3x3_unit.sv
// chan | handshake                 | payload                                         | beat
// in   | i_in_valid / o_in_ready   | i_pixel_in                                      | pixel
// out  | o_out_valid / i_out_ready | o_pixel_out, o_out_row, o_out_col, o_frame_done | result
// cfg  | i_cfg_we                  | i_cfg_idx, i_cfg_data                           | write
//
// Accepts one pixel per cycle while the queue is not full; the median pipe delivers one
// result per cycle while the output is not stalled, so on the last row (up to four results
// per pixel) input is held back. A result passes the front register, queue and median pipe.
// Synchronous active-low reset clears counters, window, queue and pipe; the
// line stores are not cleared. A 4-entry queue lets the front keep accepting
// while the output stalls; a stalled output freezes the 4-stage median pipe.
`default_nettype none

`include "median_filter_3x3_unit_defines.svh"

module median_filter_3x3_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [PIXEL_BITS-1:0]          i_pixel_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [PIXEL_BITS-1:0]               o_pixel_out,
    output logic [mf3_pkg::ROW_W-1:0]           o_out_row,
    output logic [mf3_pkg::COL_OUT_W-1:0]       o_out_col,
    output logic                                o_frame_done
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WIN_W = mf3_pkg::WIN_COLS * mf3_pkg::WIN_ROWS * PIXEL_BITS;
    localparam int Q_W   = WIN_W + mf3_pkg::ROW_W + CW + mf3_pkg::EMIT_W;

    logic                      q_push;
    logic                      q_pop;
    logic                      q_full;
    logic                      q_empty;
    logic [Q_W-1:0]            q_din;
    logic [Q_W-1:0]            q_dout;

    logic [WIN_W-1:0]          f_win;
    logic [mf3_pkg::ROW_W-1:0] f_row;
    logic [CW-1:0]             f_col;
    mf3_pkg::t_emit            f_emit;

    logic [WIN_W-1:0]          b_win;
    logic [mf3_pkg::ROW_W-1:0] b_row;
    logic [CW-1:0]             b_col;
    mf3_pkg::t_emit            b_emit;

    mf3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pixel_in (i_pixel_in),
        .o_push     (q_push),
        .i_full     (q_full),
        .o_win      (f_win),
        .o_row      (f_row),
        .o_col      (f_col),
        .o_emit     (f_emit)
    );

    assign q_din = {f_win, f_row, f_col, f_emit};

    mf3_fifo #(
        .W     (Q_W),
        .DEPTH (mf3_pkg::QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_din),
        .i_pop   (q_pop),
        .o_data  (q_dout),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {b_win, b_row, b_col, b_emit} = q_dout;

    mf3_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (!q_empty),
        .i_win        (b_win),
        .i_row        (b_row),
        .i_col        (b_col),
        .i_emit       (b_emit),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_out  (o_pixel_out),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_done (o_frame_done)
    );

    `MF3_ASSERT_NOW(a_push_not_full, q_push, !q_full, "queue written while full")
    `MF3_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty, "queue read while empty")
    `MF3_ASSERT_NEXT(a_push_lands, q_push, !q_empty, "queued entry lost")

endmodule

`default_nettype wire
